/* rtl/fragment_datagram_deframer_assert.svh */
// ----------------------------------------------------------------------------
// Fragment datagram deframer - assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_DATAGRAM_DEFRAMER_ASSERT_SVH
`define FRAGMENT_DATAGRAM_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define FDD_ASSERT_IMPLY(lbl, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, always checked
`define FDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/fdd_pkg.sv */
// ----------------------------------------------------------------------------
// fdd_pkg
// Types, constants and helpers shared by the datagram deframer modules.
// ----------------------------------------------------------------------------
package fdd_pkg;

  localparam int POS_W                  = 12;
  localparam int HDR_BYTES              = 10;
  localparam int MAX_DATAGRAM_BYTES_DEF = 2058;
  localparam int POS_LIMIT              = 4095;
  localparam logic [7:0] HDR_LEN_VALUE  = 8'd10;
  localparam logic [7:0] VERSION_RESET  = 8'd1;

  // Register word indexes on the config port
  localparam logic REG_VERSION = 1'b0;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_HLEN    = 3'd4
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        payload_byte;
    logic [15:0]       frame_tag;
    logic [7:0]        fragment_count;
    logic [7:0]        fragment_index;
    status_t           status;
    logic [POS_W-1:0]  payload_length;
    logic              last_record;
  } record_t;

  // Up to two records written into the output queue per beat
  typedef struct packed {
    logic [1:0] cnt;
    record_t    rec_a;
    record_t    rec_b;
  } push_t;

  // Magic header bytes, in order
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h53;
      2'd1:    b = 8'h57;
      2'd2:    b = 8'h54;
      default: b = 8'h46;
    endcase
    return b;
  endfunction

endpackage

/* rtl/fdd_parser.sv */
// ----------------------------------------------------------------------------
// fdd_parser
// Header check and field capture; builds the records caused by one byte.
// ----------------------------------------------------------------------------
module fdd_parser #(
  parameter int MAX_DATAGRAM_BYTES = fdd_pkg::MAX_DATAGRAM_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  logic [7:0]    expected_version,
  output fdd_pkg::push_t push
);
  import fdd_pkg::*;

  localparam int BOUND = (MAX_DATAGRAM_BYTES > POS_LIMIT) ? POS_LIMIT : MAX_DATAGRAM_BYTES;
  localparam logic [POS_W-1:0] BOUND_C = POS_W'(BOUND);
  localparam logic [POS_W-1:0] HDR_C   = POS_W'(HDR_BYTES);

  logic [POS_W-1:0] byte_position;
  logic [15:0]      held_frame_tag;
  logic [7:0]       held_fragment_count;
  logic [7:0]       held_fragment_index;
  status_t          first_error;

  logic [POS_W-1:0] pos_next;
  logic [15:0]      fid_next;
  logic [7:0]       fcnt_next;
  logic [7:0]       fidx_next;
  status_t          err_next;
  logic             pay_ok;
  record_t          pay_rec;
  record_t          stat_rec;

  // Header byte checks and field capture
  always_comb begin
    err_next  = first_error;
    fid_next  = held_frame_tag;
    fcnt_next = held_fragment_count;
    fidx_next = held_fragment_index;
    if (byte_position < POS_W'(4)) begin
      if (first_error == ST_OK && data_byte != magic_byte(byte_position[1:0])) begin
        err_next = ST_MAGIC;
      end
    end else if (byte_position == POS_W'(4)) begin
      if (first_error == ST_OK && data_byte != expected_version) begin
        err_next = ST_VERSION;
      end
    end else if (byte_position == POS_W'(5)) begin
      if (first_error == ST_OK && data_byte != HDR_LEN_VALUE) begin
        err_next = ST_HLEN;
      end
    end else if (byte_position == POS_W'(6)) begin
      fid_next = {held_frame_tag[15:8], data_byte};
    end else if (byte_position == POS_W'(7)) begin
      fid_next = {data_byte, held_frame_tag[7:0]};
    end else if (byte_position == POS_W'(8)) begin
      fcnt_next = data_byte;
    end else if (byte_position == POS_W'(9)) begin
      fidx_next = data_byte;
    end
  end

  // Saturating position count
  assign pos_next = (byte_position < BOUND_C) ? byte_position + POS_W'(1) : byte_position;
  assign pay_ok   = (byte_position >= HDR_C) && (first_error == ST_OK);

  // Payload record
  always_comb begin
    pay_rec                = '0;
    pay_rec.kind           = KIND_PAYLOAD;
    pay_rec.payload_byte   = data_byte;
    pay_rec.frame_tag      = held_frame_tag;
    pay_rec.fragment_count = held_fragment_count;
    pay_rec.fragment_index = held_fragment_index;
    pay_rec.status         = ST_OK;
  end

  // Status record, short datagram first, then first header error
  always_comb begin
    stat_rec             = '0;
    stat_rec.kind        = KIND_STATUS;
    stat_rec.last_record = 1'b1;
    if (pos_next < HDR_C) begin
      stat_rec.status = ST_SHORT;
    end else if (err_next != ST_OK) begin
      stat_rec.status = err_next;
    end else begin
      stat_rec.status         = ST_OK;
      stat_rec.frame_tag      = fid_next;
      stat_rec.fragment_count = fcnt_next;
      stat_rec.fragment_index = fidx_next;
      stat_rec.payload_length = pos_next - HDR_C;
    end
  end

  // Records for this beat, in output order
  always_comb begin
    push.cnt   = accept ? (2'(pay_ok) + 2'(last_byte)) : 2'd0;
    push.rec_a = pay_ok ? pay_rec : stat_rec;
    push.rec_b = stat_rec;
  end

  // Datagram state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      held_frame_tag      <= '0;
      held_fragment_count <= '0;
      held_fragment_index <= '0;
      first_error         <= ST_OK;
    end else if (accept) begin
      if (last_byte) begin
        byte_position       <= '0;
        held_frame_tag      <= '0;
        held_fragment_count <= '0;
        held_fragment_index <= '0;
        first_error         <= ST_OK;
      end else begin
        byte_position       <= pos_next;
        held_frame_tag      <= fid_next;
        held_fragment_count <= fcnt_next;
        held_fragment_index <= fidx_next;
        first_error         <= err_next;
      end
    end
  end

endmodule

/* rtl/fdd_queue.sv */
// ----------------------------------------------------------------------------
// fdd_queue
// Four-entry result queue; takes up to two records a beat, gives one.
// ----------------------------------------------------------------------------
module fdd_queue (
  input  logic             clk,
  input  logic             rst,
  input  fdd_pkg::push_t   push,
  input  logic             pop,
  output fdd_pkg::record_t head_rec,
  output logic             head_valid,
  output logic             full
);
  import fdd_pkg::*;

  record_t     entries [4];
  logic [1:0]  head;
  logic [1:0]  tail;
  logic [2:0]  count;
  logic [2:0]  count_next;

  assign head_rec   = entries[head];
  assign head_valid = (count != 3'd0);
  // Input holds off unless room for two records remains
  assign full       = (count > 3'd2);

  assign count_next = count + 3'(push.cnt) - 3'(pop);

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      entries[tail] <= push.rec_a;
    end
    if (push.cnt == 2'd2) begin
      entries[tail + 2'd1] <= push.rec_b;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + 2'(pop);
      tail  <= tail + push.cnt;
      count <= count_next;
    end
  end

endmodule

/* rtl/fragment_datagram_deframer.sv */
// ----------------------------------------------------------------------------
// fragment_datagram_deframer
// Checks a ten-byte fragment header and passes tagged payload bytes on.
// ----------------------------------------------------------------------------
// Input channel: one datagram byte per beat (data_byte, last_byte) under
// data_valid / data_stall. Output channel: one record per beat under
// rec_valid / rec_stall; a payload record per payload byte of a datagram
// whose header is good, and one status record after the last byte.
// Each record is written into the output queue and offered from there.
// Throughput: one byte per cycle. A last payload byte causes two records,
// which leave the four-entry output queue one at a time; the input
// stalls only while that queue holds more than two records.
// Reset (synchronous, rst high) empties the queue, clears the datagram
// state and sets expected_version to 1. While rec_stall is high the
// queue fills and data_stall rises; no record is dropped.
// Config: expected_version at APB byte address 0; the user writes it in idle time, the block does not enforce this.
// ----------------------------------------------------------------------------
module fragment_datagram_deframer #(
  parameter int MAX_DATAGRAM_BYTES = fdd_pkg::MAX_DATAGRAM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // record output
  output logic        rec_valid,
  input  logic        rec_stall,
  output logic        record_kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] frame_tag,
  output logic [7:0]  fragment_count,
  output logic [7:0]  fragment_index,
  output logic [2:0]  status,
  output logic [11:0] payload_length,
  output logic        last_record
);
  import fdd_pkg::*;

  logic [7:0] expected_version;
  logic       accept;
  logic       full;
  push_t      push;
  record_t    head_rec;

  // Config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VERSION) ? {24'd0, expected_version} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= VERSION_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_VERSION) begin
      expected_version <= pwdata[7:0];
    end
  end

  // Input handshake
  assign data_stall = full;
  assign accept     = data_valid && !full;

  fdd_parser #(
    .MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
  ) u_parser (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .expected_version(expected_version),
    .push            (push)
  );

  fdd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (rec_valid && !rec_stall),
    .head_rec  (head_rec),
    .head_valid(rec_valid),
    .full      (full)
  );

  // Record fields
  assign record_kind    = head_rec.kind;
  assign payload_byte   = head_rec.payload_byte;
  assign frame_tag      = head_rec.frame_tag;
  assign fragment_count = head_rec.fragment_count;
  assign fragment_index = head_rec.fragment_index;
  assign status         = head_rec.status;
  assign payload_length = head_rec.payload_length;
  assign last_record    = head_rec.last_record;

endmodule

/* rtl/fdd_checker.sv */
// ----------------------------------------------------------------------------
// fdd_checker
// Port-level checks on the deframer's record stream.
// ----------------------------------------------------------------------------
`include "fragment_datagram_deframer_assert.svh"

module fdd_checker (
  input logic        clk,
  input logic        rst,
  input logic        rec_valid,
  input logic        rec_stall,
  input logic        record_kind,
  input logic [15:0] frame_tag,
  input logic [2:0]  status,
  input logic [11:0] payload_length,
  input logic        last_record
);
  import fdd_pkg::*;

  // A stalled record stays offered
  `FDD_ASSERT_IMPLY(a_hold_valid, rst, rec_valid && rec_stall ##1 1'b1, rec_valid, "record dropped while stalled")

  // Status records, and only they, close a datagram
  `FDD_ASSERT_IMPLY(a_last_kind, rst, rec_valid, last_record == record_kind, "last_record does not match record kind")

  // Payload records carry no status and no length
  `FDD_ASSERT_IMPLY(a_payload_clean, rst, rec_valid && !record_kind, status == ST_OK && payload_length == 12'd0, "payload record carries status fields")

  // Failed datagrams report no frame tag and no payload length
  `FDD_ASSERT_IMPLY(a_error_clean, rst, rec_valid && record_kind && status != ST_OK, frame_tag == 16'd0 && payload_length == 12'd0, "error status carries header fields")

  // Queue is empty after reset
  `FDD_ASSERT_NEXT(a_reset_empty, rst, !rec_valid, "record offered right after reset")

endmodule

bind fragment_datagram_deframer fdd_checker u_fdd_checker (
  .clk           (clk),
  .rst           (rst),
  .rec_valid     (rec_valid),
  .rec_stall     (rec_stall),
  .record_kind   (record_kind),
  .frame_tag     (frame_tag),
  .status        (status),
  .payload_length(payload_length),
  .last_record   (last_record)
);

/* tb/sv/fragment_datagram_deframer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fragment_datagram_deframer_tb
// Self-checking bench for the fragment datagram deframer.
// A queue of datagram bytes feeds a clocked driver with random gaps. A
// clocked monitor predicts the records of every accepted byte and compares
// each accepted record with the oldest prediction, field by field. The
// receiver stalls at random. The version register is swept through several
// values between phases, while the block is idle.
// ----------------------------------------------------------------------------
module fragment_datagram_deframer_tb;
  import fdd_pkg::*;

  localparam int          MAX_BYTES     = 2058;
  localparam int          POS_BOUND     = (MAX_BYTES > POS_LIMIT) ? POS_LIMIT : MAX_BYTES;
  localparam int          IDLE_LIMIT    = 2000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          PHASE_BYTES   = 165;
  localparam logic [2:0]  VERSION_ADDR  = {REG_VERSION, 2'b00};
  localparam logic [7:0]  MAGIC_SEQ [4] = '{8'h53, 8'h57, 8'h54, 8'h46};

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } dgram_byte_t;

  // DUT ports, inputs all known from time zero
  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        data_valid     = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte      = '0;
  logic        last_byte      = 1'b0;
  logic        rec_valid;
  logic        rec_stall      = 1'b0;
  logic        record_kind;
  logic [7:0]  payload_byte;
  logic [15:0] frame_tag;
  logic [7:0]  fragment_count;
  logic [7:0]  fragment_index;
  logic [2:0]  status;
  logic [11:0] payload_length;
  logic        last_record;

  // Stimulus and expectation stores
  dgram_byte_t pending_bytes [$];
  logic [7:0]  frame_buf [$];
  record_t     expected_records [$];
  int          queued_bytes   = 0;
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  bit          byte_taken     = 1'b0;
  bit          rec_taken      = 1'b0;

  // Predictor state
  logic [7:0]  version_setting = VERSION_RESET;
  logic [11:0] seen_count      = '0;
  logic [15:0] held_fid        = '0;
  logic [7:0]  held_fcnt       = '0;
  logic [7:0]  held_fidx       = '0;
  status_t     header_fault    = ST_OK;

  // Driver / receiver pacing
  int          send_gap  = 0;
  bit          send_calm = 1'b0;
  int          hold_left = 0;
  bit          recv_calm = 1'b1;
  dgram_byte_t next_beat;

  fragment_datagram_deframer #(
    .MAX_DATAGRAM_BYTES(MAX_BYTES)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .data_valid    (data_valid),
    .data_stall    (data_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .rec_valid     (rec_valid),
    .rec_stall     (rec_stall),
    .record_kind   (record_kind),
    .payload_byte  (payload_byte),
    .frame_tag     (frame_tag),
    .fragment_count(fragment_count),
    .fragment_index(fragment_index),
    .status        (status),
    .payload_length(payload_length),
    .last_record   (last_record)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Wait cycles per beat; calm stretches give back-to-back traffic
  function automatic int draw_gap(input bit calm);
    if (calm) return 0;
    return $urandom_range(0, 1) ? $urandom_range(0, 14) : 0;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Predict the records caused by one accepted datagram byte
  task automatic deframe_byte(input logic [7:0] b, input logic lst);
    record_t     rec;
    logic [11:0] pos;
    pos = seen_count;
    if (pos < 4) begin
      if (header_fault == ST_OK && b != MAGIC_SEQ[pos[1:0]]) header_fault = ST_MAGIC;
    end else if (pos == 4) begin
      if (header_fault == ST_OK && b != version_setting) header_fault = ST_VERSION;
    end else if (pos == 5) begin
      if (header_fault == ST_OK && b != HDR_LEN_VALUE) header_fault = ST_HLEN;
    end else if (pos == 6) begin
      held_fid[7:0] = b;
    end else if (pos == 7) begin
      held_fid[15:8] = b;
    end else if (pos == 8) begin
      held_fcnt = b;
    end else if (pos == 9) begin
      held_fidx = b;
    end else if (header_fault == ST_OK) begin
      rec                = '0;
      rec.kind           = KIND_PAYLOAD;
      rec.payload_byte   = b;
      rec.frame_tag      = held_fid;
      rec.fragment_count = held_fcnt;
      rec.fragment_index = held_fidx;
      rec.status         = ST_OK;
      expected_records.insert(expected_records.size(), rec);
    end

    // byte counter saturates at the bound
    if (pos < POS_BOUND) pos++;
    seen_count = pos;

    if (lst) begin
      rec             = '0;
      rec.kind        = KIND_STATUS;
      rec.last_record = 1'b1;
      if (pos < HDR_BYTES) begin
        rec.status = ST_SHORT;
      end else if (header_fault != ST_OK) begin
        rec.status = header_fault;
      end else begin
        rec.status         = ST_OK;
        rec.frame_tag      = held_fid;
        rec.fragment_count = held_fcnt;
        rec.fragment_index = held_fidx;
        rec.payload_length = 12'(pos - HDR_BYTES);
      end
      expected_records.insert(expected_records.size(), rec);
      seen_count   = '0;
      held_fid     = '0;
      held_fcnt    = '0;
      held_fidx    = '0;
      header_fault = ST_OK;
    end
  endtask

  task automatic check_record();
    record_t want;
    if (expected_records.size() == 0) begin
      $display("%0t ns: unexpected record, expected none, got kind %0d status %0d byte %0h",
               $time, record_kind, status, payload_byte);
      mismatch_count++;
    end else begin
      want = expected_records.pop_front();
      check_field("record_kind",    want.kind,           record_kind);
      check_field("payload_byte",   want.payload_byte,   payload_byte);
      check_field("frame_tag",      want.frame_tag,      frame_tag);
      check_field("fragment_count", want.fragment_count, fragment_count);
      check_field("fragment_index", want.fragment_index, fragment_index);
      check_field("status",         want.status,         status);
      check_field("payload_length", want.payload_length, payload_length);
      check_field("last_record",    want.last_record,    last_record);
    end
  endtask

  // Monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    byte_taken = 1'b0;
    rec_taken  = 1'b0;
    if (!rst) begin
      if (rec_valid && !rec_stall) begin
        rec_taken = 1'b1;
        check_record();
      end
      if (data_valid && !data_stall) begin
        byte_taken = 1'b1;
        deframe_byte(data_byte, last_byte);
      end
      quiet_cycles = (byte_taken || rec_taken) ? 0 : quiet_cycles + 1;
    end
  end

  // Driver: next byte goes out at a falling edge once the previous beat is taken and the random gap has run out
  always @(negedge clk) begin
    if (!rst && (!data_valid || byte_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        data_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        next_beat  = pending_bytes.pop_front();
        data_byte  <= next_beat.value;
        last_byte  <= next_beat.last;
        data_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        send_gap = draw_gap(send_calm);
      end else begin
        data_valid <= 1'b0;
      end
    end
  end

  // Receiver: hold off each record for a random number of cycles
  always @(negedge clk) begin
    if (!rst) begin
      if (rec_taken) begin
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        hold_left = draw_gap(recv_calm);
      end
      if (rec_valid && hold_left > 0) begin
        hold_left--;
        rec_stall <= 1'b1;
      end else if (!rec_valid) begin
        rec_stall <= !recv_calm && ($urandom_range(0, 3) == 0);
      end else begin
        rec_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any beat on either channel
  initial begin
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t ns: no beat for %0d cycles", $time, IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Register write, then read back
  task automatic write_version(input logic [7:0] v);
    logic [31:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VERSION_ADDR;
    pwdata  <= {24'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    version_setting = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("expected_version readback", {8'h00, v}, readback[15:0]);
  endtask

  // Header into frame_buf; payload is appended by the caller
  task automatic frame_header(input logic [7:0] ver, input logic [7:0] hlen,
                              input logic [15:0] fid, input logic [7:0] cnt,
                              input logic [7:0] idx);
    frame_buf = '{MAGIC_SEQ[0], MAGIC_SEQ[1], MAGIC_SEQ[2], MAGIC_SEQ[3],
                  ver, hlen, fid[7:0], fid[15:8], cnt, idx};
  endtask

  // Move frame_buf to the send queue, last mark on its final byte
  task automatic send_datagram();
    dgram_byte_t beat;
    foreach (frame_buf[i]) begin
      beat.value = frame_buf[i];
      beat.last  = (i == frame_buf.size() - 1);
      pending_bytes.insert(pending_bytes.size(), beat);
      queued_bytes++;
    end
    frame_buf.delete();
  endtask

  // Mostly good datagrams; some with broken headers, truncated, or noise
  task automatic queue_random_datagram();
    int shape;
    int plen;
    int total;
    bit hit;
    shape = $urandom_range(0, 99);
    plen  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 12);
    frame_header(version_setting, HDR_LEN_VALUE, 16'($urandom), 8'($urandom), 8'($urandom));
    repeat (plen) frame_buf.insert(frame_buf.size(), 8'($urandom));
    if (shape >= 75 && shape < 85) begin
      // corrupt one or more checked header bytes
      hit = 1'b0;
      while (!hit) begin
        for (int i = 0; i < 6; i++) begin
          if ($urandom_range(0, 3) == 0) begin
            frame_buf[i] ^= 8'($urandom_range(1, 255));
            hit = 1'b1;
          end
        end
      end
    end else if (shape >= 85 && shape < 95) begin
      // cut inside the header, sometimes with a bad byte too
      total = $urandom_range(1, HDR_BYTES - 1);
      if ($urandom_range(0, 1)) frame_buf[$urandom_range(0, total - 1)] ^= 8'($urandom_range(1, 255));
      while (frame_buf.size() > total) void'(frame_buf.pop_back());
    end else if (shape >= 95) begin
      frame_buf.delete();
      total = $urandom_range(1, 40);
      repeat (total) frame_buf.insert(frame_buf.size(), 8'($urandom));
    end
    send_datagram();
  endtask

  // Wait until every byte is sent and every record has come, then let it settle
  task automatic settle_idle();
    while (pending_bytes.size() != 0 || data_valid || expected_records.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus sequence
  initial begin : stimulus
    logic [7:0] plan [4];
    int         phase_start;
    plan = '{8'h00, 8'hFF, 8'($urandom_range(2, 254)), VERSION_RESET};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: one-byte datagram, short and bad magic at once
    frame_buf = '{8'h00};
    send_datagram();
    // header only, all-ones fields
    frame_header(version_setting, HDR_LEN_VALUE, 16'hFFFF, 8'hFF, 8'hFF);
    send_datagram();
    // all-zero fields, two payload bytes at the extremes
    frame_header(version_setting, HDR_LEN_VALUE, 16'h0000, 8'h00, 8'h00);
    frame_buf.insert(frame_buf.size(), 8'h00);
    frame_buf.insert(frame_buf.size(), 8'hFF);
    send_datagram();
    // wrong version: no payload records
    frame_header(version_setting ^ 8'h80, HDR_LEN_VALUE, 16'h1234, 8'h05, 8'h02);
    frame_buf.insert(frame_buf.size(), 8'hAB);
    send_datagram();
    // wrong header length
    frame_header(version_setting, 8'h0B, 16'hA55A, 8'h03, 8'h01);
    frame_buf.insert(frame_buf.size(), 8'h5A);
    send_datagram();
    // nine bytes with bad magic and version: too short still wins
    frame_header(version_setting ^ 8'h01, HDR_LEN_VALUE, 16'h8001, 8'h7F, 8'h80);
    frame_buf[1] = 8'h00;
    void'(frame_buf.pop_back());
    send_datagram();
    settle_idle();

    // Random phases over a sweep of version settings
    foreach (plan[p]) begin
      write_version(plan[p]);
      phase_start = queued_bytes;
      while (queued_bytes - phase_start < PHASE_BYTES) queue_random_datagram();
      settle_idle();
    end

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* fragment_datagram_deframer.f */
+incdir+rtl
rtl/fdd_pkg.sv
rtl/fdd_parser.sv
rtl/fdd_queue.sv
rtl/fragment_datagram_deframer.sv
rtl/fdd_checker.sv
tb/sv/fragment_datagram_deframer_tb.sv
